// ===== rtl/spi_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the segment / plane intersection block
// no dependencies
package spi_pkg;

  localparam int CRD_W = 32;          // coordinate width
  localparam int NRM_W = 16;          // normal component width
  localparam int DIF_W = CRD_W + 1;   // endpoint difference width
  localparam int MAG_W = 54;          // numerator / denominator width, covers any normal scale
  localparam int QUO_W = 32;          // quotient bits produced by the divider
  localparam int REM_W = MAG_W + QUO_W + 1;
  localparam int PRD_W = DIF_W + CRD_W;

  localparam logic [CRD_W-1:0] T_MAX = {1'b0, {(CRD_W-1){1'b1}}};
  localparam logic [CRD_W-1:0] T_MIN = {1'b1, {(CRD_W-1){1'b0}}};

  typedef enum logic [1:0] {
    REG_NORMAL_X,
    REG_NORMAL_Y,
    REG_NORMAL_Z,
    REG_PLANE_OFFSET
  } reg_idx_e;

  // classified segment handed from the front end to the divider
  typedef struct packed {
    logic [2:0][CRD_W-1:0] start;
    logic [2:0][DIF_W-1:0] diff;
    logic [MAG_W-1:0]      ua;
    logic [MAG_W-1:0]      ub;
    logic                  neg;
    logic                  par;
    logic                  num_zero;
    logic                  in_range;
  } spi_item_t;

  // one divider stage
  typedef struct packed {
    logic [2:0][CRD_W-1:0] start;
    logic [2:0][DIF_W-1:0] diff;
    logic [MAG_W-1:0]      ub;
    logic [REM_W-1:0]      rem;
    logic [QUO_W-1:0]      quo;
    logic                  neg;
    logic                  par;
    logic                  num_zero;
    logic                  in_range;
    logic                  ovf;
  } spi_div_t;

endpackage

// ===== rtl/segment_plane_intersection.sv =====
`timescale 1ns / 1ps
// top level of the segment / plane intersection block: plane registers and wiring
// depends on spi_pkg, spi_front, spi_queue, spi_back
//
// usage
// - software writes the plane over the apb port: normal x/y/z (Q1.14) at 0x0, 0x4,
//   0x8 and the plane offset (Q16.16) at 0xc; writes only while the block is idle
// - segment requests enter on in_valid_i / in_stall_o, one endpoint pair per request
// - results leave on out_valid_o / out_stall_i: hit, t_valid, t and crossing point
// - throughput is one request per cycle unless a stall holds the flow; a request passes
//   four front end stages, the queue, the restoring divider (an entry stage, then 32
//   stages of one quotient bit each) and three stages for t and the point
// - a four entry queue separates the front end from the divider pipeline, so each
//   side stalls on its own
// - while out_stall_i holds a result, the whole back pipeline freezes; the front end
//   keeps taking requests until the queue is full and its last stage holds a request
// - reset empties all pipelines and the queue and loads the plane y = 0 (normal
//   pointing along y, offset zero)
module segment_plane_intersection import spi_pkg::*; #(
  parameter int COORD_FRAC_BITS  = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // segment requests
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [CRD_W-1:0] start_x_i,
  input  logic [CRD_W-1:0] start_y_i,
  input  logic [CRD_W-1:0] start_z_i,
  input  logic [CRD_W-1:0] end_x_i,
  input  logic [CRD_W-1:0] end_y_i,
  input  logic [CRD_W-1:0] end_z_i,
  // results
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             hit_o,
  output logic             t_valid_o,
  output logic [CRD_W-1:0] t_value_o,
  output logic [CRD_W-1:0] point_x_o,
  output logic [CRD_W-1:0] point_y_o,
  output logic [CRD_W-1:0] point_z_o
);

  logic [2:0][NRM_W-1:0] normal_q;
  logic [CRD_W-1:0]      offset_q;
  reg_idx_e              reg_sel;
  logic                  wr_en;

  logic      q_full, q_empty, push, pop;
  spi_item_t item, head;

  // register index from the word address, low address bits ignored
  assign reg_sel = reg_idx_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_q[0] <= '0;
      normal_q[1] <= NRM_W'(1 << NORMAL_FRAC_BITS);
      normal_q[2] <= '0;
      offset_q    <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_NORMAL_X:     normal_q[0] <= pwdata[NRM_W-1:0];
        REG_NORMAL_Y:     normal_q[1] <= pwdata[NRM_W-1:0];
        REG_NORMAL_Z:     normal_q[2] <= pwdata[NRM_W-1:0];
        REG_PLANE_OFFSET: offset_q    <= pwdata;
        default:          ;
      endcase
    end
  end

  // read back, normal components zero extended
  always_comb begin
    unique case (reg_sel)
      REG_NORMAL_X:     prdata = 32'(normal_q[0]);
      REG_NORMAL_Y:     prdata = 32'(normal_q[1]);
      REG_NORMAL_Z:     prdata = 32'(normal_q[2]);
      REG_PLANE_OFFSET: prdata = offset_q;
      default:          prdata = '0;
    endcase
  end

  // front end: difference vector, dot products, sign handling
  spi_front #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o,
    .start_x_i, .start_y_i, .start_z_i,
    .end_x_i, .end_y_i, .end_z_i,
    .normal_i (normal_q),
    .offset_i (offset_q),
    .q_full_i (q_full),
    .push_o   (push),
    .item_o   (item)
  );

  // decoupling queue
  spi_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .item_i  (item),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head)
  );

  // divider, t saturation and crossing point
  spi_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .q_empty_i (q_empty),
    .head_i    (head),
    .pop_o     (pop),
    .out_valid_o, .out_stall_i,
    .hit_o, .t_valid_o, .t_value_o,
    .point_x_o, .point_y_o, .point_z_o
  );

endmodule

// ===== rtl/spi_front.sv =====
`timescale 1ns / 1ps
// front end: difference, dot products and classification of one segment per cycle unless stalled by a full queue
// depends on spi_pkg
module spi_front import spi_pkg::*; #(
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [CRD_W-1:0]        start_x_i,
  input  logic [CRD_W-1:0]        start_y_i,
  input  logic [CRD_W-1:0]        start_z_i,
  input  logic [CRD_W-1:0]        end_x_i,
  input  logic [CRD_W-1:0]        end_y_i,
  input  logic [CRD_W-1:0]        end_z_i,
  input  logic [2:0][NRM_W-1:0]   normal_i,
  input  logic [CRD_W-1:0]        offset_i,
  input  logic                    q_full_i,
  output logic                    push_o,
  output spi_item_t               item_o
);

  logic en;
  logic f1_v_q, f2_v_q, f3_v_q, f4_v_q;

  logic [2:0][CRD_W-1:0]   f1_s_q, f2_s_q, f3_s_q;
  logic [2:0][DIF_W-1:0]   f1_d_q, f2_d_q, f3_d_q;
  logic signed [DIF_W+NRM_W-1:0] f2_nd_q [3];
  logic signed [CRD_W+NRM_W-1:0] f2_ns_q [3];
  logic signed [MAG_W-1:0] f2_off_q;
  logic signed [MAG_W-1:0] f3_den_q, f3_num_q;
  spi_item_t               f4_q, f4_d;

  logic [2:0][CRD_W-1:0] in_s, in_e;
  logic signed [MAG_W-1:0] a, b;

  assign in_s = {start_z_i, start_y_i, start_x_i};
  assign in_e = {end_z_i, end_y_i, end_x_i};

  assign en         = !f4_v_q || !q_full_i;
  assign in_stall_o = !en;
  assign push_o     = f4_v_q && !q_full_i;
  assign item_o     = f4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
      f3_v_q <= 1'b0;
      f4_v_q <= 1'b0;
    end else if (en) begin
      f1_v_q <= in_valid_i;
      f2_v_q <= f1_v_q;
      f3_v_q <= f2_v_q;
      f4_v_q <= f3_v_q;
    end
  end

  // classification: t = a / b with b made positive
  always_comb begin
    a = f3_den_q[MAG_W-1] ? f3_num_q : -f3_num_q;
    b = f3_den_q[MAG_W-1] ? -f3_den_q : f3_den_q;
    f4_d.start    = f3_s_q;
    f4_d.diff     = f3_d_q;
    f4_d.neg      = a[MAG_W-1];
    f4_d.ua       = a[MAG_W-1] ? MAG_W'(-a) : MAG_W'(a);
    f4_d.ub       = MAG_W'(b);
    f4_d.par      = (f3_den_q == '0);
    f4_d.num_zero = (f3_num_q == '0);
    f4_d.in_range = !a[MAG_W-1] && (a <= b);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        f1_s_q[i] <= in_s[i];
        f1_d_q[i] <= DIF_W'($signed(in_e[i])) - DIF_W'($signed(in_s[i]));
        f2_nd_q[i] <= $signed(normal_i[i]) * $signed(f1_d_q[i]);
        f2_ns_q[i] <= $signed(normal_i[i]) * $signed(f1_s_q[i]);
      end
      f2_off_q <= MAG_W'($signed(offset_i)) <<< NORMAL_FRAC_BITS;
      f2_s_q   <= f1_s_q;
      f2_d_q   <= f1_d_q;
      f3_den_q <= MAG_W'(f2_nd_q[0]) + MAG_W'(f2_nd_q[1]) + MAG_W'(f2_nd_q[2]);
      f3_num_q <= MAG_W'(f2_ns_q[0]) + MAG_W'(f2_ns_q[1]) + MAG_W'(f2_ns_q[2]) + f2_off_q;
      f3_s_q   <= f2_s_q;
      f3_d_q   <= f2_d_q;
      f4_q     <= f4_d;
    end
  end

endmodule

// ===== rtl/spi_queue.sv =====
`timescale 1ns / 1ps
// four entry queue between front end and divider back end
// depends on spi_pkg
module spi_queue import spi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  spi_item_t item_i,
  input  logic      pop_i,
  output logic      full_o,
  output logic      empty_o,
  output spi_item_t head_o
);

  localparam int DEPTH = 4;

  spi_item_t  mem_q [DEPTH];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic       do_pop;

  assign full_o  = (cnt_q == 3'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 2'd1;
      if (do_pop) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + 3'(push_i) - 3'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

endmodule

// ===== rtl/spi_back.sv =====
`timescale 1ns / 1ps
// back end: pipelined restoring divider, t saturation, crossing point
// depends on spi_pkg
module spi_back import spi_pkg::*; #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  spi_item_t        head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             hit_o,
  output logic             t_valid_o,
  output logic [CRD_W-1:0] t_value_o,
  output logic [CRD_W-1:0] point_x_o,
  output logic [CRD_W-1:0] point_y_o,
  output logic [CRD_W-1:0] point_z_o
);

  logic en;
  logic     dv_q [QUO_W+1];
  spi_div_t dp_q [QUO_W+1];
  spi_div_t dnx  [QUO_W+1];

  logic                  tv_q, mv_q, ov_q;
  logic [2:0][CRD_W-1:0] ts_q, ms_q;
  logic [2:0][DIF_W-1:0] td_q;
  logic [CRD_W-1:0]      tt_q, mt_q;
  logic                  thit_q, tpar_q, mhit_q, mpar_q;
  logic signed [PRD_W-1:0] mprod_q [3];

  logic                  hit_q, tval_q;
  logic [CRD_W-1:0]      t_q;
  logic [2:0][CRD_W-1:0] p_q;

  logic [CRD_W-1:0]      t_d;
  logic                  sat_d;
  logic [REM_W-1:0]      lim, sh [QUO_W+1];
  logic [2:0][CRD_W-1:0] p_d;
  logic signed [PRD_W-1:0] trc [3];
  logic signed [PRD_W:0]   sum [3];

  assign en    = !ov_q || !out_stall_i;
  assign pop_o = en && !q_empty_i;

  // divider: one quotient bit per stage, overflow check on entry
  always_comb begin
    dnx[0].start    = head_i.start;
    dnx[0].diff     = head_i.diff;
    dnx[0].ub       = head_i.ub;
    dnx[0].rem      = REM_W'(head_i.ua) << COORD_FRAC_BITS;
    dnx[0].quo      = '0;
    dnx[0].neg      = head_i.neg;
    dnx[0].par      = head_i.par;
    dnx[0].num_zero = head_i.num_zero;
    dnx[0].in_range = head_i.in_range;
    lim             = REM_W'(head_i.ub) << QUO_W;
    dnx[0].ovf      = (dnx[0].rem >= lim);
    sh[0]           = lim;
    for (int j = 1; j <= QUO_W; j++) begin
      dnx[j] = dp_q[j-1];
      sh[j]  = REM_W'(dp_q[j-1].ub) << (QUO_W - j);
      if (dp_q[j-1].rem >= sh[j]) begin
        dnx[j].rem           = dp_q[j-1].rem - sh[j];
        dnx[j].quo[QUO_W-j]  = 1'b1;
      end
    end
  end

  // saturation of t, t forced to zero for a parallel segment
  always_comb begin
    if (dp_q[QUO_W].neg) begin
      sat_d = dp_q[QUO_W].ovf || (dp_q[QUO_W].quo > T_MIN);
      t_d   = sat_d ? T_MIN : -dp_q[QUO_W].quo;
    end else begin
      sat_d = dp_q[QUO_W].ovf || dp_q[QUO_W].quo[QUO_W-1];
      t_d   = sat_d ? T_MAX : dp_q[QUO_W].quo;
    end
    if (dp_q[QUO_W].par) t_d = '0;
  end

  // truncate toward zero, add start, saturate; a miss gives zero, a parallel hit gives the start
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      trc[i] = mprod_q[i][PRD_W-1] ? -((-mprod_q[i]) >>> COORD_FRAC_BITS)
                                   : (mprod_q[i] >>> COORD_FRAC_BITS);
      sum[i] = (PRD_W+1)'($signed(ms_q[i])) + (PRD_W+1)'(trc[i]);
      if (sum[i] > (PRD_W+1)'($signed(T_MAX)))      p_d[i] = T_MAX;
      else if (sum[i] < (PRD_W+1)'($signed(T_MIN))) p_d[i] = T_MIN;
      else                                          p_d[i] = sum[i][CRD_W-1:0];
      if (!mhit_q)     p_d[i] = '0;
      else if (mpar_q) p_d[i] = ms_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j <= QUO_W; j++) dv_q[j] <= 1'b0;
      tv_q <= 1'b0;
      mv_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (en) begin
      dv_q[0] <= !q_empty_i;
      for (int j = 1; j <= QUO_W; j++) dv_q[j] <= dv_q[j-1];
      tv_q <= dv_q[QUO_W];
      mv_q <= tv_q;
      ov_q <= mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j <= QUO_W; j++) dp_q[j] <= dnx[j];
      ts_q   <= dp_q[QUO_W].start;
      td_q   <= dp_q[QUO_W].diff;
      tt_q   <= t_d;
      tpar_q <= dp_q[QUO_W].par;
      thit_q <= dp_q[QUO_W].par ? dp_q[QUO_W].num_zero : dp_q[QUO_W].in_range;
      for (int i = 0; i < 3; i++) mprod_q[i] <= $signed(td_q[i]) * $signed(tt_q);
      ms_q   <= ts_q;
      mt_q   <= tt_q;
      mhit_q <= thit_q;
      mpar_q <= tpar_q;
      hit_q  <= mhit_q;
      tval_q <= !mpar_q;
      t_q    <= mt_q;
      p_q    <= p_d;
    end
  end

  assign out_valid_o = ov_q;
  assign hit_o       = hit_q;
  assign t_valid_o   = tval_q;
  assign t_value_o   = t_q;
  assign point_x_o   = p_q[0];
  assign point_y_o   = p_q[1];
  assign point_z_o   = p_q[2];

endmodule

// ===== rtl/spi_checker.sv =====
`timescale 1ns / 1ps
// port level checks for the segment / plane intersection block, bound to the top level
// depends on segment_plane_intersection
module spi_checker #(
  parameter int COORD_FRAC_BITS = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        hit_o,
  input logic        t_valid_o,
  input logic [31:0] t_value_o,
  input logic [31:0] point_x_o,
  input logic [31:0] point_y_o,
  input logic [31:0] point_z_o
);

  localparam logic signed [31:0] T_ONE = 32'sd1 <<< COORD_FRAC_BITS;

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // parallel segment reports t as zero
  a_par_t: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !t_valid_o |-> t_value_o == '0)
    else $error("t not zero on parallel segment");

  // a miss reports the origin as point
  a_miss_pt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> point_x_o == '0 && point_y_o == '0 && point_z_o == '0)
    else $error("point not zero on miss");

  // a crossing lies within the segment
  a_hit_t: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o && t_valid_o |->
      $signed(t_value_o) >= 0 && $signed(t_value_o) <= T_ONE)
    else $error("hit with t outside the segment");

endmodule

bind segment_plane_intersection spi_checker #(
  .COORD_FRAC_BITS(COORD_FRAC_BITS)
) u_spi_checker (.*);
